FILE: rtl/i2a_pkg.sv
// Shared constants, types and helper functions for the binary to ASCII
// radix converter. Used by i2a_ctrl, i2a_dpath and int_to_ascii_radix.
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

    // Width of the converted number; bits of the input above it are ignored.
    localparam int VALUE_BITS   = 64;

    localparam int HEX_DIGITS   = (VALUE_BITS + 3) / 4;
    localparam int OCT_DIGITS   = (VALUE_BITS + 2) / 3;
    // 1233/4096 approximates log10(2)
    localparam int DEC_DIGITS   = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int PAD_BITS     = HEX_DIGITS * 4;
    // Double dabble takes four source bits per cycle
    localparam int DABBLE_STEPS = HEX_DIGITS;
    localparam int MAX_DIGITS   = OCT_DIGITS;
    localparam int MAX_CHARS    = (OCT_DIGITS > DEC_DIGITS + 1) ? OCT_DIGITS
                                                                : DEC_DIGITS + 1;
    localparam int WIDE_BITS    = (MAX_DIGITS + 1) * 4;

    localparam int STEP_W       = (DABBLE_STEPS > 1) ? $clog2(DABBLE_STEPS) : 1;
    localparam int DIG_IDX_W    = $clog2(MAX_DIGITS);
    localparam int NDIG_W       = $clog2(MAX_DIGITS + 1);

    // Port widths
    localparam int S_TDATA_W    = 64;
    localparam int S_TUSER_W    = 2;
    localparam int CHAR_W       = 7;
    localparam int LEN_W        = 5;
    localparam int M_TDATA_W    = 16;
    localparam int M_PAD_W      = M_TDATA_W - CHAR_W - LEN_W;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;

    typedef enum logic [1:0] {
        CMD_OCT  = 2'd0,
        CMD_UDEC = 2'd1,
        CMD_HEX  = 2'd2,
        CMD_SDEC = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic conv;
        logic count;
        logic emit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_dec;
        logic conv_done;
        logic emit_last;
        logic out_free;
    } dp_sts_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {3'b000, d};
        end else begin
            c = CHAR_A + {3'b000, d} - 7'd10;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/int_to_ascii_radix.sv
// Top level of the binary to ASCII radix converter.
// Joins i2a_ctrl and i2a_dpath; uses i2a_pkg for widths and types.
//
// Usage:
//   Input channel s_*: one word per number. s_tdata carries the value,
//   s_tuser the format (0 octal, 1 unsigned decimal, 2 lower-case hex,
//   3 signed decimal). Only the low VALUE_BITS bits of the value are used.
//   Output channel m_*: one word per character, most significant digit
//   first, a leading '-' for negative signed values. Every word carries the
//   total string length; m_tlast marks the final character.
//   Timing: the input is accepted while idle; hex and octal then pass through
//   the conversion state unchanged, while decimal runs the double dabble
//   unit, which shifts four bits per cycle, until all source bits are in.
//   A count state then counts digits, and one character per cycle, while
//   the receiver accepts, leaves through the output register.
//   One number is worked on at a time; s_tready is high only while idle.
//   A stalled receiver holds the current character in the output register
//   and pauses emission. Reset clears the controller and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module int_to_ascii_radix (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: [63:0] value
    input  wire logic [i2a_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: [1:0] cmd
    input  wire logic [i2a_pkg::S_TUSER_W-1:0]  s_tuser,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // m_tdata: [6:0] ascii_char, [11:7] text_length, [15:12] zero
    output logic [i2a_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready
);

    i2a_pkg::dp_cmd_t dp_cmd;
    i2a_pkg::dp_sts_t dp_sts;

    i2a_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    i2a_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (dp_cmd),
        .sts      (dp_sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/i2a_ctrl.sv
// Sequencing state machine of the radix converter: load, convert, count
// digits, emit characters. Depends on i2a_pkg; drives i2a_dpath.
`timescale 1ns / 1ps
`default_nettype none

module i2a_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire i2a_pkg::dp_sts_t sts,
    output i2a_pkg::dp_cmd_t     cmd
);

    i2a_pkg::state_t state_reg;
    i2a_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= i2a_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            i2a_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = i2a_pkg::ST_CONV;
                end
            end
            i2a_pkg::ST_CONV: begin
                if (!sts.is_dec || sts.conv_done) begin
                    state_next = i2a_pkg::ST_COUNT;
                end
            end
            i2a_pkg::ST_COUNT: begin
                state_next = i2a_pkg::ST_EMIT;
            end
            i2a_pkg::ST_EMIT: begin
                if (sts.out_free && sts.emit_last) begin
                    state_next = i2a_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = i2a_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            i2a_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            i2a_pkg::ST_CONV: begin
                cmd.conv = sts.is_dec;
            end
            i2a_pkg::ST_COUNT: begin
                cmd.count = 1'b1;
            end
            i2a_pkg::ST_EMIT: begin
                cmd.emit = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/i2a_dpath.sv
// Datapath of the radix converter: magnitude and BCD registers, double
// dabble step, digit count, character select and output register. Uses i2a_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2a_dpath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [i2a_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic [i2a_pkg::S_TUSER_W-1:0]  s_tuser,
    input  wire i2a_pkg::dp_cmd_t               cmd,
    output i2a_pkg::dp_sts_t                    sts,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [i2a_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast
);

    localparam int BCD_W = i2a_pkg::DEC_DIGITS * 4;

    i2a_pkg::cmd_t                       cmd_reg;
    logic                                neg_reg;
    logic [i2a_pkg::PAD_BITS-1:0]        mag_reg;
    logic [BCD_W-1:0]                    bcd_reg;
    logic [i2a_pkg::STEP_W-1:0]          step_reg;
    logic [i2a_pkg::NDIG_W-1:0]          ndig_reg;
    logic [i2a_pkg::DIG_IDX_W-1:0]       idx_reg;
    logic                                sign_pend_reg;
    logic                                out_valid_reg;
    logic [i2a_pkg::CHAR_W-1:0]          out_char_reg;
    logic [i2a_pkg::LEN_W-1:0]           out_len_reg;
    logic                                out_last_reg;

    logic [i2a_pkg::VALUE_BITS-1:0]      val_in;
    logic [i2a_pkg::VALUE_BITS-1:0]      mag_in;
    logic                                neg_in;
    logic [BCD_W-1:0]                    bcd_next;
    logic [3:0]                          in_bits;
    logic [i2a_pkg::WIDE_BITS-1:0]       src_wide;
    logic [i2a_pkg::WIDE_BITS-1:0]       bcd_wide;
    logic [3:0]                          dig [i2a_pkg::MAX_DIGITS];
    logic [i2a_pkg::NDIG_W-1:0]          ndig_next;
    logic [i2a_pkg::CHAR_W-1:0]          char_next;
    logic                                emit_last;
    logic                                bcd_ok;

    // Sign and magnitude of the incoming word
    always_comb begin
        val_in = s_tdata[i2a_pkg::VALUE_BITS-1:0];
        neg_in = (i2a_pkg::cmd_t'(s_tuser) == i2a_pkg::CMD_SDEC)
                 && val_in[i2a_pkg::VALUE_BITS-1];
        mag_in = neg_in ? (~val_in + 1'b1) : val_in;
    end

    // Four double dabble bit steps per cycle
    always_comb begin
        in_bits  = mag_reg[i2a_pkg::PAD_BITS-1 -: 4];
        bcd_next = bcd_reg;
        for (int b = 0; b < 4; b++) begin
            for (int d = 0; d < i2a_pkg::DEC_DIGITS; d++) begin
                if (bcd_next[4*d +: 4] >= 4'd5) begin
                    bcd_next[4*d +: 4] = bcd_next[4*d +: 4] + 4'd3;
                end
            end
            bcd_next = {bcd_next[BCD_W-2:0], in_bits[3-b]};
        end
    end

    // Digit view for the selected radix
    always_comb begin
        src_wide = i2a_pkg::WIDE_BITS'(mag_reg);
        bcd_wide = i2a_pkg::WIDE_BITS'(bcd_reg);
        for (int i = 0; i < i2a_pkg::MAX_DIGITS; i++) begin
            case (cmd_reg)
                i2a_pkg::CMD_OCT: dig[i] = {1'b0, src_wide[3*i +: 3]};
                i2a_pkg::CMD_HEX: dig[i] = src_wide[4*i +: 4];
                default:          dig[i] = bcd_wide[4*i +: 4];
            endcase
        end
    end

    // Significant digit count; zero still gives one digit
    always_comb begin
        ndig_next = i2a_pkg::NDIG_W'(1);
        for (int i = 1; i < i2a_pkg::MAX_DIGITS; i++) begin
            if (dig[i] != 4'd0) begin
                ndig_next = i2a_pkg::NDIG_W'(i + 1);
            end
        end
    end

    always_comb begin
        char_next = sign_pend_reg ? i2a_pkg::CHAR_MINUS
                                  : i2a_pkg::digit_char(dig[idx_reg]);
        emit_last = !sign_pend_reg && (idx_reg == '0);
    end

    always_comb begin
        bcd_ok = 1'b1;
        for (int d = 0; d < i2a_pkg::DEC_DIGITS; d++) begin
            if (bcd_reg[4*d +: 4] > 4'd9) begin
                bcd_ok = 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= i2a_pkg::cmd_t'(s_tuser);
            neg_reg <= neg_in;
            mag_reg <= i2a_pkg::PAD_BITS'(mag_in);
            bcd_reg <= '0;
        end else if (cmd.conv) begin
            mag_reg <= mag_reg << 4;
            bcd_reg <= bcd_next;
        end
        if (cmd.count) begin
            ndig_reg      <= ndig_next;
            idx_reg       <= i2a_pkg::DIG_IDX_W'(ndig_next - i2a_pkg::NDIG_W'(1));
            sign_pend_reg <= neg_reg;
        end else if (cmd.emit) begin
            if (sign_pend_reg) begin
                sign_pend_reg <= 1'b0;
            end else if (idx_reg != '0) begin
                idx_reg <= idx_reg - 1'b1;
            end
        end
        if (cmd.emit) begin
            out_char_reg <= char_next;
            out_len_reg  <= i2a_pkg::LEN_W'(ndig_reg) + i2a_pkg::LEN_W'(neg_reg);
            out_last_reg <= emit_last;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                step_reg <= '0;
            end else if (cmd.conv) begin
                step_reg <= step_reg + 1'b1;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        sts.is_dec    = (cmd_reg == i2a_pkg::CMD_UDEC) || (cmd_reg == i2a_pkg::CMD_SDEC);
        sts.conv_done = (step_reg == i2a_pkg::STEP_W'(i2a_pkg::DABBLE_STEPS - 1));
        sts.emit_last = emit_last;
        sts.out_free  = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{i2a_pkg::M_PAD_W{1'b0}}, out_len_reg, out_char_reg};
    assign m_tlast  = out_last_reg;

    // Digit index stays inside the counted digits while emitting
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && !sign_pend_reg |-> i2a_pkg::NDIG_W'(idx_reg) < ndig_reg)
        else $error("digit index beyond digit count");

    // Count always lands between one and the widest digit string
    a_ndig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.count |=> (ndig_reg != '0)
                      && (ndig_reg <= i2a_pkg::NDIG_W'(i2a_pkg::MAX_DIGITS)))
        else $error("digit count out of range");

    // Finished conversion leaves valid BCD digits only
    a_bcd_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.conv && sts.conv_done |=> bcd_ok)
        else $error("BCD digit above nine after conversion");

    // A word is only loaded into the output register when it is free
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("output word overwritten while stalled");

endmodule

`default_nettype wire
